/* design/sbdc_pkg.sv */
// shared types and constants for the serial block deframer
// no dependencies
package sbdc_pkg;

  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned CountOutW     = 16;
  localparam int unsigned LineW         = 15;
  localparam int unsigned TdataW        = 56;

  localparam logic [7:0] DefBlockLen = 8'd64;
  localparam logic [7:0] MarkerByte  = 8'd255;
  localparam logic [7:0] SumModFinal = 8'd254;

  localparam logic KindByte  = 1'b0;
  localparam logic KindClear = 1'b1;

  // keyword characters
  localparam logic [7:0] ChD = 8'd100;
  localparam logic [7:0] ChE = 8'd101;
  localparam logic [7:0] ChF = 8'd102;
  localparam logic [7:0] ChG = 8'd103;
  localparam logic [7:0] ChH = 8'd104;
  localparam logic [7:0] ChI = 8'd105;
  localparam logic [7:0] ChL = 8'd108;
  localparam logic [7:0] ChN = 8'd110;
  localparam logic [7:0] ChO = 8'd111;
  localparam logic [7:0] ChP = 8'd112;
  localparam logic [7:0] ChR = 8'd114;
  localparam logic [7:0] ChS = 8'd115;
  localparam logic [7:0] ChT = 8'd116;
  localparam logic [7:0] ChU = 8'd117;
  localparam logic [7:0] ChW = 8'd119;

  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdUp    = 3'd1,
    CmdRight = 3'd2,
    CmdLeft  = 3'd3,
    CmdDown  = 3'd4,
    CmdStop  = 3'd5
  } cmd_e;

  // element 3 is the newest earlier byte
  typedef logic [3:0][7:0] recent_t;

  typedef struct packed {
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic              header_done;
    logic [LineW-1:0]  line_count;
    cmd_e              command;
    logic              dir_a;
    logic              dir_b;
    logic              drive_on;
    logic              block_done;
    logic              checksum_ok;
    logic [7:0]        computed_sum;
    logic [CountOutW-1:0] block_count;
  } res_t;

endpackage

/* design/serial_block_deframer_commands_unit.sv */
// serial block deframer top: input register, deframer core, result register
// an accepted item is held in the input register; its result is then captured in the result register
// throughput: one item per cycle while the output is not stalled, set by the single-pass core between the two registers
// back-pressure stalls both registers; ready depends combinationally on m_axis_tready
// reset (async, active low) clears the valid flags and all core state, block length returns to 64
// depends on sbdc_pkg and sbdc_core
module serial_block_deframer_commands_unit #(
  parameter int unsigned CountWidth = sbdc_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte
  input  logic                          s_axis_tuser,  // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // payload_byte, header_done, line_count, command, dir_a, dir_b, drive_on,
  // checksum_ok, computed_sum, block_count, zero pad
  output logic [sbdc_pkg::TdataW-1:0]   m_axis_tdata,
  output logic                          m_axis_tuser,  // payload_valid
  output logic                          m_axis_tlast,  // block_done
  input  logic                          cfg_wr_en_i,
  input  logic [7:0]                    cfg_wr_data_i
);
  import sbdc_pkg::*;

  logic       in_vld_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  res_t       out_q;
  res_t       res;
  logic       adv;
  logic       step;
  logic       s_acc;

  assign adv           = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  sbdc_core #(
    .CountWidth (CountWidth)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .kind_i     (in_kind_q),
    .byte_i     (in_byte_q),
    .cfg_we_i   (cfg_wr_en_i),
    .cfg_data_i (cfg_wr_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tlast  = out_q.block_done;
  assign m_axis_tdata  = {1'b0, out_q.block_count, out_q.computed_sum, out_q.checksum_ok,
                          out_q.drive_on, out_q.dir_b, out_q.dir_a, out_q.command,
                          out_q.line_count, out_q.header_done, out_q.payload_byte};

  a_check_vs_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("check item flagged as payload");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[38:31] != 8'd0 && m_axis_tdata[38:31] != 8'd255)
    else $error("computed sum out of range");

  a_ok_only_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[30])
    else $error("checksum ok without check item");

  a_cmd_only_on_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[26:24] == CmdNone)
    else $error("command on non-payload item");

endmodule

/* design/sbdc_kwmatch.sv */
// keyword detector over the recent payload bytes and the current byte
// depends on sbdc_pkg
module sbdc_kwmatch (
  input  sbdc_pkg::recent_t recent_i,
  input  logic [7:0]        byte_i,
  output sbdc_pkg::cmd_e    cmd_o
);
  import sbdc_pkg::*;

  always_comb begin
    cmd_o = CmdNone;
    if (recent_i[3] == ChU && byte_i == ChP) begin
      cmd_o = CmdUp;
    end else if (recent_i[0] == ChR && recent_i[1] == ChI && recent_i[2] == ChG &&
                 recent_i[3] == ChH && byte_i == ChT) begin
      cmd_o = CmdRight;
    end else if (recent_i[1] == ChL && recent_i[2] == ChE && recent_i[3] == ChF &&
                 byte_i == ChT) begin
      cmd_o = CmdLeft;
    end else if (recent_i[1] == ChD && recent_i[2] == ChO && recent_i[3] == ChW &&
                 byte_i == ChN) begin
      cmd_o = CmdDown;
    end else if (recent_i[1] == ChS && recent_i[2] == ChT && recent_i[3] == ChO &&
                 byte_i == ChP) begin
      cmd_o = CmdStop;
    end
  end

endmodule

/* design/sbdc_core.sv */
// deframer state: header parse, block position, running sum, motor bits, counters
// depends on sbdc_pkg and sbdc_kwmatch
module sbdc_core #(
  parameter int unsigned CountWidth = sbdc_pkg::CountWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             kind_i,
  input  logic [7:0]       byte_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  output sbdc_pkg::res_t   res_o
);
  import sbdc_pkg::*;

  localparam logic [2:0] HdrEnd  = 3'(HeaderBytes);
  localparam logic [2:0] HdrPos0 = 3'd0;
  localparam logic [2:0] HdrPos1 = 3'd1;
  localparam logic [2:0] HdrLen  = 3'd2;
  localparam int unsigned ExtW   = CountOutW + CountWidth;

  logic [2:0]            hdr_pos_q, hdr_pos_d;
  logic [7:0]            hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  logic [7:0]            pend_len_q, pend_len_d;
  logic                  started_q, started_d;
  logic [7:0]            blen_q, blen_d;
  logic [7:0]            bpos_q, bpos_d;
  logic [7:0]            sum_q, sum_d;
  recent_t               rec_q, rec_d;
  logic [2:0]            motor_q, motor_d;
  logic [LineW-1:0]      line_q, line_d;
  logic [CountWidth-1:0] blocks_q, blocks_d;

  cmd_e                  kw_cmd;
  logic signed [15:0]    lc;
  logic [8:0]            sum9;
  logic [7:0]            sum_next;
  logic [7:0]            fin;
  logic [ExtW-1:0]       cnt_ext;

  sbdc_kwmatch u_kwmatch (
    .recent_i (rec_q),
    .byte_i   (byte_i),
    .cmd_o    (kw_cmd)
  );

  assign lc = ($signed({8'b0, hdr0_q}) - 16'sd100) * 16'sd100
            + ($signed({8'b0, hdr1_q}) - 16'sd100);

  assign sum9 = {1'b0, sum_q} + {1'b0, byte_i};

  always_comb begin
    if (sum9 >= 9'd508) begin
      sum_next = 8'(sum9 - 9'd508);
    end else if (sum9 >= 9'd254) begin
      sum_next = 8'(sum9 - 9'd254);
    end else begin
      sum_next = sum9[7:0];
    end
  end

  assign fin = (sum_q == 8'd0) ? SumModFinal : sum_q;

  // next state
  always_comb begin
    hdr_pos_d  = hdr_pos_q;
    hdr0_d     = hdr0_q;
    hdr1_d     = hdr1_q;
    pend_len_d = pend_len_q;
    started_d  = started_q;
    blen_d     = blen_q;
    bpos_d     = bpos_q;
    sum_d      = sum_q;
    rec_d      = rec_q;
    motor_d    = motor_q;
    line_d     = line_q;
    blocks_d   = blocks_q;
    if (step_i) begin
      if (kind_i == KindClear) begin
        hdr_pos_d  = '0;
        hdr0_d     = '0;
        hdr1_d     = '0;
        pend_len_d = '0;
        started_d  = 1'b0;
        bpos_d     = '0;
        sum_d      = '0;
        rec_d      = '0;
        motor_d    = '0;
        line_d     = '0;
        blocks_d   = '0;
      end else if (hdr_pos_q < HdrEnd) begin
        unique case (hdr_pos_q)
          HdrPos0: hdr0_d = byte_i;
          HdrPos1: hdr1_d = byte_i;
          HdrLen:  pend_len_d = byte_i;
          default: begin
            if (byte_i == MarkerByte && !started_q) begin
              line_d    = lc[LineW-1:0];
              blen_d    = pend_len_q;
              started_d = 1'b1;
            end
          end
        endcase
        hdr_pos_d = hdr_pos_q + 3'd1;
      end else if (bpos_q < blen_q) begin
        sum_d = sum_next;
        case (kw_cmd)
          CmdUp:    motor_d = 3'b100;
          CmdRight: motor_d = 3'b101;
          CmdLeft:  motor_d = 3'b110;
          CmdDown:  motor_d = 3'b111;
          CmdStop:  motor_d = {1'b0, motor_q[1:0]};
          default:  motor_d = motor_q;
        endcase
        rec_d  = {byte_i, rec_q[3:1]};
        bpos_d = bpos_q + 8'd1;
      end else begin
        blocks_d = blocks_q + 1'b1;
        sum_d    = '0;
        bpos_d   = '0;
        rec_d    = '0;
      end
    end
    if (cfg_we_i) begin
      blen_d = cfg_data_i;
    end
  end

  assign cnt_ext = {{CountOutW{1'b0}}, blocks_d};

  // result fields
  always_comb begin
    res_o               = '0;
    res_o.command       = CmdNone;
    res_o.line_count    = line_d;
    res_o.dir_a         = motor_d[0];
    res_o.dir_b         = motor_d[1];
    res_o.drive_on      = motor_d[2];
    res_o.block_count   = cnt_ext[CountOutW-1:0];
    res_o.computed_sum  = (sum_d == 8'd0) ? SumModFinal : sum_d;
    if (step_i && kind_i == KindByte) begin
      if (hdr_pos_q < HdrEnd) begin
        res_o.header_done = (hdr_pos_q == HdrEnd - 3'd1) && byte_i == MarkerByte &&
                            !started_q;
      end else if (bpos_q < blen_q) begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.command       = kw_cmd;
      end else begin
        res_o.block_done   = 1'b1;
        res_o.checksum_ok  = (fin == byte_i);
        res_o.computed_sum = fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q  <= '0;
      hdr0_q     <= '0;
      hdr1_q     <= '0;
      pend_len_q <= '0;
      started_q  <= 1'b0;
      blen_q     <= DefBlockLen;
      bpos_q     <= '0;
      sum_q      <= '0;
      rec_q      <= '0;
      motor_q    <= '0;
      line_q     <= '0;
      blocks_q   <= '0;
    end else begin
      hdr_pos_q  <= hdr_pos_d;
      hdr0_q     <= hdr0_d;
      hdr1_q     <= hdr1_d;
      pend_len_q <= pend_len_d;
      started_q  <= started_d;
      blen_q     <= blen_d;
      bpos_q     <= bpos_d;
      sum_q      <= sum_d;
      rec_q      <= rec_d;
      motor_q    <= motor_d;
      line_q     <= line_d;
      blocks_q   <= blocks_d;
    end
  end

endmodule
